### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define PBA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("page bitmap allocator assertion failed");

// Property checked on every rising edge, reset included.
`define PBA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("page bitmap allocator assertion failed");

`endif

### rtl/pba_pkg.sv
`default_nettype none

package pba_pkg;

  // Default number of pages covered by the bitmap.
  localparam int unsigned DEF_PAGES = 65536;

  // Page size and its address shift.
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

  // Pages held by one bitmap word.
  localparam int unsigned WORD_BITS = 64;

  // Register reset values.
  localparam logic [13:0] BITMAP_BYTES_RST = 14'd8192;
  localparam logic [63:0] MAP_OFFSET_RST   = 64'd0;

  // Configuration register indexes.
  localparam logic REG_BITMAP_BYTES = 1'b0;
  localparam logic REG_MAP_OFFSET   = 1'b1;

  // Input actions.
  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_RESERVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NONE_FREE = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

### rtl/page_bitmap_allocator_core.sv
`default_nettype none
// First-fit page frame allocator over a used-page bitmap held in one RAM.
// Input beats carry an action (allocate, release, reserve) and a page index;
// every accepted beat gives exactly one result beat with a status, the
// granted page and its address (page * 4096 + map offset); page and address
// are zero unless an allocate succeeds. Configuration (bitmap size in bytes,
// map offset) is to be written through the cfg port only while the block is
// idle; the block itself does not enforce it.
// Release and reserve pass through ST_WRITE to ST_RESP; an out-of-range
// page or the unused action code goes straight to ST_RESP. An allocate
// scans in ST_SCAN until it finds a free page, then passes through ST_WRITE
// to ST_RESP; one that finds no free page scans every word in use first.
// The scan reads one 64-bit bitmap word per cycle from the single RAM read
// port; one item is in work at a time and in_tready is low meanwhile.
// Reset runs a clearing pass that writes every bitmap word to all ones
// (every page used), one word after another, with in_tready low. A stalled
// receiver holds the result in the output register; the next item is
// taken meanwhile but its result waits in the sequencer until the output
// register is free.
module page_bitmap_allocator_core #(
  parameter int unsigned PAGES = pba_pkg::DEF_PAGES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input beats.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [1:0] action, [17:2] page, rest zero
  // Result beats.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // [1:0] status, [17:2] granted_page,
                                       // [81:18] address, rest zero
  // Configuration writes.
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);
  import pba_pkg::*;

  localparam int unsigned WORDS  = PAGES / WORD_BITS;
  localparam int unsigned WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CNT_W  = $clog2(WORDS + 1);
  localparam int unsigned PG_W   = $clog2(PAGES);

  // Bitmap memory and its registered read data.
  logic [63:0]       mem [WORDS];
  logic [63:0]       rd_data_r;
  logic              mem_re;
  logic [WORD_W-1:0] mem_raddr;
  logic              mem_we;
  logic [WORD_W-1:0] mem_waddr;
  logic [63:0]       mem_wdata;

  // Sequencer and item registers.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  ic_r, ic_nxt;        // clearing pass word
  logic [CNT_W-1:0]  iw_r, iw_nxt;        // next word to read in the scan
  logic [WORD_W-1:0] cw_r, cw_nxt;        // word whose data is in rd_data_r
  logic              cv_r, cv_nxt;        // rd_data_r holds a word to check
  logic [WORD_W-1:0] wa_r, wa_nxt;        // word to rewrite
  logic [5:0]        bit_r, bit_nxt;      // bit to set or clear
  logic              set_r, set_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic [PG_W-1:0]   gpage_r, gpage_nxt;
  logic              aok_r, aok_nxt;      // allocate succeeded

  // Configuration registers.
  logic [13:0]       bb_r;
  logic [63:0]       off_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_stat_r, out_stat_nxt;
  logic [15:0]       out_page_r, out_page_nxt;
  logic [63:0]       out_addr_r, out_addr_nxt;

  // Input fields.
  logic [1:0]        in_action;
  logic [15:0]       in_page;
  logic              in_acc;

  // Bitmap limits derived from the configuration.
  logic [31:0]       bb32;
  logic [31:0]       lim;
  logic [31:0]       lim_full;
  logic [31:0]       nw32;
  logic [CNT_W-1:0]  nw;

  // Release and reserve addressing.
  logic [31:0]       pw;
  logic [31:0]       pw_fold;

  // Scan check of one word.
  logic [63:0]       valid_mask;
  logic [63:0]       free_bits;
  logic              found;
  logic [5:0]        fb;
  logic              issue;
  logic              out_free;

  assign in_action = in_tdata[1:0];
  assign in_page   = in_tdata[17:2];
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Pages in use, clamped to the bitmap, and words to scan.
  always_comb begin
    bb32     = 32'(bb_r);
    lim      = ((bb32 > 32'(PAGES / 8)) ? 32'(PAGES / 8) : bb32) << 3;
    lim_full = lim >> 6;
    nw32     = (lim + 32'd63) >> 6;
    if (nw32 > 32'(WORDS)) begin
      nw32 = 32'(WORDS);
    end
    nw = CNT_W'(nw32);
  end

  // Word index of the requested page, folded into the bitmap.
  always_comb begin
    pw      = 32'(in_page) >> 6;
    pw_fold = (pw >= 32'(WORDS)) ? (pw - 32'(WORDS)) : pw;
  end

  // Free pages of the word under check and the lowest of them.
  always_comb begin
    for (int b = 0; b < 64; b++) begin
      valid_mask[b] = (32'(cw_r) < lim_full) || (6'(b) < lim[5:0]);
    end
    free_bits = ~rd_data_r & valid_mask;
    found     = cv_r && (free_bits != 64'd0);
    fb        = 6'd0;
    for (int b = 63; b >= 0; b--) begin
      if (free_bits[b]) begin
        fb = 6'(b);
      end
    end
    issue = (iw_r < nw) && !found;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (ic_r == CNT_W'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_action == ACT_ALLOC) begin
            state_nxt = ST_SCAN;
          end else if ((in_action == ACT_RELEASE || in_action == ACT_RESERVE) &&
                       (32'(in_page) < lim)) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_nxt = ST_WRITE;
        end else if (iw_r >= nw) begin
          state_nxt = ST_RESP;
        end
      end
      ST_WRITE: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // Memory control, handshake and register next values.
  always_comb begin
    in_tready     = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = iw_r[WORD_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = wa_r;
    mem_wdata     = set_r ? (rd_data_r | (64'd1 << bit_r))
                          : (rd_data_r & ~(64'd1 << bit_r));
    ic_nxt        = ic_r;
    iw_nxt        = iw_r;
    cw_nxt        = cw_r;
    cv_nxt        = cv_r;
    wa_nxt        = wa_r;
    bit_nxt       = bit_r;
    set_nxt       = set_r;
    stat_nxt      = stat_r;
    gpage_nxt     = gpage_r;
    aok_nxt       = aok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_page_nxt  = out_page_r;
    out_addr_nxt  = out_addr_r;
    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ic_r[WORD_W-1:0];
        mem_wdata = '1;
        ic_nxt    = ic_r + CNT_W'(1);
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        iw_nxt    = '0;
        cv_nxt    = 1'b0;
        aok_nxt   = 1'b0;
        gpage_nxt = '0;
        wa_nxt    = WORD_W'(pw_fold);
        bit_nxt   = in_page[5:0];
        set_nxt   = (in_action == ACT_RESERVE);
        if ((in_action == ACT_RELEASE || in_action == ACT_RESERVE) &&
            (32'(in_page) >= lim)) begin
          stat_nxt = STAT_RANGE;
        end else begin
          stat_nxt = STAT_OK;
        end
        // Release and reserve read their word right away.
        if (in_acc && (in_action == ACT_RELEASE || in_action == ACT_RESERVE) &&
            (32'(in_page) < lim)) begin
          mem_re    = 1'b1;
          mem_raddr = WORD_W'(pw_fold);
        end
      end
      ST_SCAN: begin
        // Read one word per cycle while checking the one read before.
        if (issue) begin
          mem_re = 1'b1;
          iw_nxt = iw_r + CNT_W'(1);
          cw_nxt = iw_r[WORD_W-1:0];
          cv_nxt = 1'b1;
        end else begin
          cv_nxt = 1'b0;
        end
        if (found) begin
          wa_nxt    = cw_r;
          bit_nxt   = fb;
          set_nxt   = 1'b1;
          stat_nxt  = STAT_OK;
          gpage_nxt = PG_W'({cw_r, fb});
          aok_nxt   = 1'b1;
        end else begin
          stat_nxt  = STAT_NONE_FREE;
        end
      end
      ST_WRITE: begin
        mem_we = 1'b1;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          out_page_nxt  = 16'(gpage_r);
          out_addr_nxt  = aok_r ? ((64'(gpage_r) << PAGE_SHIFT) + off_r) : 64'd0;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Bitmap memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ic_r        <= '0;
      out_valid_r <= 1'b0;
      bb_r        <= BITMAP_BYTES_RST;
      off_r       <= MAP_OFFSET_RST;
    end else begin
      state_r     <= state_nxt;
      ic_r        <= ic_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_BITMAP_BYTES: bb_r  <= cfg_data[13:0];
          REG_MAP_OFFSET:   off_r <= cfg_data;
          default:          bb_r  <= bb_r;
        endcase
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    iw_r       <= iw_nxt;
    cw_r       <= cw_nxt;
    cv_r       <= cv_nxt;
    wa_r       <= wa_nxt;
    bit_r      <= bit_nxt;
    set_r      <= set_nxt;
    stat_r     <= stat_nxt;
    gpage_r    <= gpage_nxt;
    aok_r      <= aok_nxt;
    out_stat_r <= out_stat_nxt;
    out_page_r <= out_page_nxt;
    out_addr_r <= out_addr_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_addr_r, out_page_r, out_stat_r};

endmodule

`default_nettype wire

### rtl/pba_checker.sv
`default_nettype none
`include "assert_macros.svh"

module pba_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata
);
  import pba_pkg::*;

  // A held result beat keeps its payload until taken.
  `PBA_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // A failed item never reports a page or an address.
  `PBA_ASSERT(a_fail_zero, clk, rst_n, out_tvalid && out_tdata[1:0] != STAT_OK |-> out_tdata[81:2] == 80'd0)

  // An accepted beat keeps the block busy in the next cycle.
  `PBA_ASSERT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready)

  // Reset starts the clearing pass with no result pending.
  `PBA_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !in_tready && !out_tvalid)

endmodule

bind page_bitmap_allocator_core pba_checker u_pba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
